/* rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and the byte class table of the scene text tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned LineW = 16;

    // lexer mode, one-hot
    typedef enum logic [3:0] {
        MODE_SKIP    = 4'b0001,
        MODE_COMMENT = 4'b0010,
        MODE_WORD    = 4'b0100,
        MODE_NUMBER  = 4'b1000
    } t_mode;

    typedef enum logic [2:0] {
        CLS_ERR = 3'd0,
        CLS_SPC = 3'd1,
        CLS_WRD = 3'd2,
        CLS_NUM = 3'd3,
        CLS_OTH = 3'd4
    } t_class;

    localparam logic [2:0] KIND_PUNCT  = 3'd0;
    localparam logic [2:0] KIND_WORD   = 3'd1;
    localparam logic [2:0] KIND_NUMBER = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;

    localparam logic [ByteW-1:0] CH_LF      = 8'h0A;
    localparam logic [ByteW-1:0] CH_CR      = 8'h0D;
    localparam logic [ByteW-1:0] CH_LOWER   = 8'h20;
    localparam logic [ByteW-1:0] CH_COMMENT = 8'h3E;
    localparam logic [ByteW-1:0] CH_E       = 8'h65;
    localparam logic [ByteW-1:0] CH_DOT     = 8'h2E;
    localparam logic [ByteW-1:0] CH_MINUS   = 8'h2D;

    localparam logic [ByteW-1:0] MaxLenReset = 8'd80;
    localparam logic [LineW-1:0] LineMax     = 16'hFFFF;

    typedef struct packed {
        logic [ByteW-1:0] token_byte;
        logic [2:0]       token_kind;
        logic             last_of_token;
        logic [1:0]       error_code;
        logic [LineW-1:0] line_number;
    } t_result;

    function automatic t_class byte_class(input logic [ByteW-1:0] b);
        t_class c;
        if ((b >= 8'h09 && b <= 8'h0D) || b == 8'h20 || b == 8'h2C ||
            b == 8'h5B || b == 8'h5D || b == 8'h7B || b == 8'h7D) begin
            c = CLS_SPC;
        end else if (b == 8'h2D || b == 8'h2E || (b >= 8'h30 && b <= 8'h39)) begin
            c = CLS_NUM;
        end else if ((b >= 8'h41 && b <= 8'h5A) || b == 8'h5F ||
                     (b >= 8'h61 && b <= 8'h7A)) begin
            c = CLS_WRD;
        end else if (b >= 8'h21 && b <= 8'h7F) begin
            c = CLS_OTH;
        end else begin
            c = CLS_ERR;
        end
        return c;
    endfunction

endpackage

/* rtl/scene_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// scene_text_tokenizer
// Streaming tokenizer: bytes in, classified token bytes with line numbers out
// ----------------------------------------------------------------------------
// output: results of an accepted request are registered in the result queue first
// throughput: one request per cycle while the queue has room; a request can yield
//   two results; the four-entry queue drains one result per cycle under i_ready
// reset: synchronous active low; clears lexer state, line counter to one and
//   the length limit to 80
module scene_text_tokenizer
    import stt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [ByteW-1:0] i_in_byte,
    input  logic             i_end_of_input,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [ByteW-1:0] i_cfg_max_token_length,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ByteW-1:0] o_token_byte,
    output logic [2:0]       o_token_kind,
    output logic             o_last_of_token,
    output logic [1:0]       o_error_code,
    output logic [LineW-1:0] o_line_number
);

    logic [ByteW-1:0] r_max_len;
    t_mode            r_mode,   n_mode;
    logic [ByteW-1:0] r_held,   n_held;
    logic             r_hv,     n_hv;
    logic             r_dot,    n_dot;
    logic             r_exp,    n_exp;
    logic [ByteW-1:0] r_len,    n_len;
    logic [LineW-1:0] r_line,   n_line;
    logic             r_halted, n_halted;

    t_result    res [2];
    logic [1:0] cnt;
    logic [1:0] push_cnt;
    logic       accept;
    logic       room;
    t_result    out_res;
    t_class     cls;
    logic       take;
    logic       do_skip;
    logic       do_append;
    logic [ByteW-1:0] b;
    logic [2:0] tok_kind;

    assign accept      = i_valid && o_ready;
    assign o_ready     = room;
    assign o_cfg_ready = 1'b1;
    assign push_cnt    = accept ? cnt : 2'd0;

    always_comb begin
        n_mode    = r_mode;
        n_held    = r_held;
        n_hv      = r_hv;
        n_dot     = r_dot;
        n_exp     = r_exp;
        n_len     = r_len;
        n_line    = r_line;
        n_halted  = r_halted;
        res[0]    = '0;
        res[1]    = '0;
        cnt       = 2'd0;
        take      = 1'b0;
        do_skip   = 1'b0;
        do_append = 1'b0;
        b         = i_in_byte;
        cls       = byte_class(i_in_byte);
        tok_kind  = (r_mode == MODE_WORD) ? KIND_WORD : KIND_NUMBER;

        if (r_halted) begin
            cnt = 2'd0;
        end else if (i_end_of_input) begin
            if ((r_mode == MODE_WORD || r_mode == MODE_NUMBER) && r_hv) begin
                res[cnt[0]] = '{r_held, tok_kind, 1'b1, ERR_NONE, r_line};
                cnt = cnt + 2'd1;
            end
            if (r_mode == MODE_WORD || r_mode == MODE_NUMBER) begin
                n_hv = 1'b0;
            end
            n_mode = MODE_SKIP;
            res[cnt[0]] = '{8'd0, KIND_END, 1'b1, ERR_NONE, r_line};
            cnt = cnt + 2'd1;
        end else begin
            unique case (r_mode)
                MODE_COMMENT: begin
                    if (b == CH_LF || b == CH_CR) begin
                        n_mode  = MODE_SKIP;
                        do_skip = 1'b1;
                    end
                end
                MODE_WORD: begin
                    take = (cls == CLS_WRD) || (cls == CLS_NUM);
                end
                MODE_NUMBER: begin
                    if (b == CH_DOT) begin
                        take = !r_dot && !r_exp;
                        if (take) begin
                            n_dot = 1'b1;
                        end
                    end else if (b == CH_E) begin
                        take = !r_exp;
                        if (take) begin
                            n_exp = 1'b1;
                        end
                    end else if (b == CH_MINUS) begin
                        take = r_hv && ((r_held | CH_LOWER) == CH_E);
                    end else begin
                        take = (cls == CLS_NUM);
                    end
                end
                default: begin
                    do_skip = 1'b1;
                end
            endcase

            if (r_mode == MODE_WORD || r_mode == MODE_NUMBER) begin
                if (take) begin
                    do_append = 1'b1;
                end else begin
                    // token ends: release held byte, then treat byte as in skip mode
                    if (r_hv) begin
                        res[cnt[0]] = '{r_held, tok_kind, 1'b1, ERR_NONE, r_line};
                        cnt = cnt + 2'd1;
                    end
                    n_hv    = 1'b0;
                    n_mode  = MODE_SKIP;
                    do_skip = 1'b1;
                end
            end

            if (do_skip) begin
                if (cls == CLS_SPC) begin
                    if (b == CH_LF && r_line != LineMax) begin
                        n_line = r_line + 16'd1;
                    end
                end else if (b == CH_COMMENT) begin
                    n_mode = MODE_COMMENT;
                end else if (cls == CLS_OTH) begin
                    res[cnt[0]] = '{b, KIND_PUNCT, 1'b1, ERR_NONE, r_line};
                    cnt = cnt + 2'd1;
                end else if (cls == CLS_WRD || cls == CLS_NUM) begin
                    n_len     = '0;
                    n_hv      = 1'b0;
                    n_dot     = (b == CH_DOT);
                    n_exp     = 1'b0;
                    n_mode    = (cls == CLS_WRD) ? MODE_WORD : MODE_NUMBER;
                    do_append = 1'b1;
                end else begin
                    res[cnt[0]] = '{b, KIND_ERROR, 1'b1, ERR_BAD_CHAR, r_line};
                    cnt = cnt + 2'd1;
                    n_halted = 1'b1;
                    n_hv     = 1'b0;
                    n_mode   = MODE_SKIP;
                end
            end

            if (do_append) begin
                tok_kind = (n_mode == MODE_WORD) ? KIND_WORD : KIND_NUMBER;
                if (n_len >= r_max_len) begin
                    res[cnt[0]] = '{b, KIND_ERROR, 1'b1, ERR_TOO_LONG, r_line};
                    cnt = cnt + 2'd1;
                    n_halted = 1'b1;
                    n_hv     = 1'b0;
                    n_mode   = MODE_SKIP;
                end else begin
                    if (n_hv) begin
                        res[cnt[0]] = '{n_held, tok_kind, 1'b0, ERR_NONE, r_line};
                        cnt = cnt + 2'd1;
                    end
                    n_held = b;
                    n_hv   = 1'b1;
                    n_len  = n_len + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MaxLenReset;
            r_mode    <= MODE_SKIP;
            r_held    <= '0;
            r_hv      <= 1'b0;
            r_dot     <= 1'b0;
            r_exp     <= 1'b0;
            r_len     <= '0;
            r_line    <= 16'd1;
            r_halted  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_len <= i_cfg_max_token_length;
            end
            if (accept) begin
                r_mode   <= n_mode;
                r_held   <= n_held;
                r_hv     <= n_hv;
                r_dot    <= n_dot;
                r_exp    <= n_exp;
                r_len    <= n_len;
                r_line   <= n_line;
                r_halted <= n_halted;
            end
        end
    end

    stt_result_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res[0]),
        .i_res1     (res[1]),
        .o_room     (room),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_token_byte    = out_res.token_byte;
    assign o_token_kind    = out_res.token_kind;
    assign o_last_of_token = out_res.last_of_token;
    assign o_error_code    = out_res.error_code;
    assign o_line_number   = out_res.line_number;

endmodule

/* rtl/stt_result_fifo.sv */
// ----------------------------------------------------------------------------
// stt_result_fifo
// Four-entry result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module stt_result_fifo
    import stt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_res
);

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       pop;

    assign pop     = (r_count != 3'd0) && i_ready;
    assign o_valid = (r_count != 3'd0);
    assign o_room  = (r_count <= 3'd2);
    assign o_res   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push_cnt;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + {1'b0, i_push_cnt} - {2'b00, pop};
        end
    end

endmodule
